// File: rtl/pcam_pkg.sv
// Shared types and constants for the per-client anomaly monitor.
package pcam_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ABNORMAL_LIMIT    = 2'd2;

    localparam logic [15:0] RST_MAX_PACKET_RATE   = 16'd100;
    localparam logic [15:0] RST_MAX_PAYLOAD_BYTES = 16'd1024;
    localparam logic [7:0]  RST_ABNORMAL_LIMIT    = 8'd5;

    localparam logic [7:0] ABNORMAL_COUNT_MAX = 8'd255;

    typedef enum logic [0:0] {
        OP_PACKET = 1'b0,
        OP_CLEAR  = 1'b1
    } operation_t;

    typedef enum logic [2:0] {
        V_REGISTERED = 3'd0,
        V_NORMAL     = 3'd1,
        V_ABNORMAL   = 3'd2,
        V_WARNED     = 3'd3,
        V_THROTTLED  = 3'd4,
        V_CLEARED    = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

    typedef struct packed {
        operation_t  operation;
        logic [5:0]  client_slot;
        logic [15:0] payload_bytes;
        logic [31:0] now_seconds;
    } item_t;

    typedef struct packed {
        verdict_t verdict;
        logic     allowed;
    } result_t;

endpackage

// File: rtl/per_client_anomaly_monitor.sv
// Per-client anomaly monitor: client table in one synchronous memory, read-modify-write.
// After the accepting edge the item passes through READ and EVAL; busy stays high until IDLE,
// so one item is finished before the next is taken. The item takes a memory read, a rate-bound
// multiply stage and an evaluate/write-back stage. Each result is flagged by done, high for one
// cycle; the receiver cannot stall it. After reset a clearing pass invalidates every slot in turn;
// busy stays high meanwhile, configuration writes are taken throughout.
module per_client_anomaly_monitor #(
    parameter int NUM_CLIENTS       = 64,
    parameter int PACKET_COUNT_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pcam_pkg::item_t                    item,
    output logic                               done,
    output pcam_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcam_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data
);
    import pcam_pkg::*;

    localparam int IDX_W   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int BOUND_W = 49;

    typedef struct packed {
        logic                         valid;
        logic [31:0]                  start_time;
        logic [PACKET_COUNT_BITS-1:0] packets;
        logic [7:0]                   abn_count;
        logic                         warned;
    } entry_t;

    entry_t mem [NUM_CLIENTS];

    state_t state_reg, state_next;

    logic [15:0] max_rate_reg;
    logic [15:0] max_payload_reg;
    logic [7:0]  abn_limit_reg;

    logic [IDX_W-1:0] clr_cnt_reg;

    item_t                        item_reg;
    entry_t                       rd_entry_reg;
    logic [BOUND_W-1:0]           bound_reg;
    logic                         elapsed_nz_reg;
    logic [PACKET_COUNT_BITS-1:0] pk_inc_reg;

    logic    done_reg;
    result_t result_reg, result_next;

    logic             accept;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;

    logic [IDX_W+5:0] in_slot_ext;
    logic [IDX_W+5:0] reg_slot_ext;
    logic [IDX_W-1:0] in_addr;
    logic [IDX_W-1:0] reg_addr;
    logic             slot_ok;

    logic [31:0]      elapsed;
    logic [BOUND_W-1:0] pk_ext;
    logic             abnormal;
    logic [7:0]       abn_up;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;

    // slot field is fixed at 6 bits; table index width follows the depth
    assign in_slot_ext  = {{IDX_W{1'b0}}, item.client_slot};
    assign reg_slot_ext = {{IDX_W{1'b0}}, item_reg.client_slot};
    assign in_addr      = in_slot_ext[IDX_W-1:0];
    assign reg_addr     = reg_slot_ext[IDX_W-1:0];
    assign slot_ok      = 32'(item_reg.client_slot) < 32'(NUM_CLIENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(NUM_CLIENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg    <= RST_MAX_PACKET_RATE;
            max_payload_reg <= RST_MAX_PAYLOAD_BYTES;
            abn_limit_reg   <= RST_ABNORMAL_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_PACKET_RATE:   max_rate_reg    <= cfg_data;
                CFG_MAX_PAYLOAD_BYTES: max_payload_reg <= cfg_data;
                CFG_ABNORMAL_LIMIT:    abn_limit_reg   <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            done_reg <= (state_reg == ST_EVAL);
        end
    end

    // table memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_entry_reg <= mem[in_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    assign elapsed = item_reg.now_seconds - rd_entry_reg.start_time;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_READ)
        begin
            bound_reg      <= ({33'd0, max_rate_reg} + 49'd1) * {17'd0, elapsed};
            elapsed_nz_reg <= (elapsed != 32'd0);
            pk_inc_reg     <= (&rd_entry_reg.packets) ? rd_entry_reg.packets
                                                      : rd_entry_reg.packets + 1'b1;
        end
        if (state_reg == ST_EVAL)
        begin
            result_reg <= result_next;
        end
    end

    assign pk_ext = BOUND_W'(pk_inc_reg);
    assign abn_up = (rd_entry_reg.abn_count == ABNORMAL_COUNT_MAX)
                  ? rd_entry_reg.abn_count : rd_entry_reg.abn_count + 8'd1;

    always_comb
    begin
        wr_en               = 1'b0;
        wr_addr             = reg_addr;
        wr_entry            = rd_entry_reg;
        result_next.verdict = V_ABNORMAL;
        result_next.allowed = 1'b0;
        abnormal            = 1'b0;

        if (state_reg == ST_CLEAR)
        begin
            wr_en          = 1'b1;
            wr_addr        = clr_cnt_reg;
            wr_entry.valid = 1'b0;
        end
        else if (state_reg == ST_EVAL && slot_ok)
        begin
            if (item_reg.operation == OP_CLEAR)
            begin
                result_next.verdict = V_CLEARED;
                if (rd_entry_reg.valid)
                begin
                    wr_en              = 1'b1;
                    wr_entry.abn_count = 8'd0;
                    wr_entry.warned    = 1'b0;
                end
            end
            else if (!rd_entry_reg.valid)
            begin
                wr_en               = 1'b1;
                wr_entry.valid      = 1'b1;
                wr_entry.start_time = item_reg.now_seconds;
                wr_entry.packets    = '0;
                wr_entry.abn_count  = 8'd0;
                wr_entry.warned     = 1'b0;
                result_next.verdict = V_REGISTERED;
                result_next.allowed = 1'b1;
            end
            else
            begin
                wr_en            = 1'b1;
                wr_entry.packets = pk_inc_reg;
                // window judged and restarted once a second has gone by
                if (elapsed_nz_reg)
                begin
                    abnormal            = (pk_ext >= bound_reg);
                    wr_entry.packets    = '0;
                    wr_entry.start_time = item_reg.now_seconds;
                end
                if (item_reg.payload_bytes > max_payload_reg)
                begin
                    abnormal = 1'b1;
                end

                if (!abnormal)
                begin
                    if (rd_entry_reg.abn_count != 8'd0)
                    begin
                        wr_entry.abn_count = rd_entry_reg.abn_count - 8'd1;
                    end
                    result_next.verdict = V_NORMAL;
                    result_next.allowed = 1'b1;
                end
                else if (abn_up >= abn_limit_reg)
                begin
                    if (!rd_entry_reg.warned)
                    begin
                        wr_entry.warned     = 1'b1;
                        wr_entry.abn_count  = abn_limit_reg >> 1;
                        result_next.verdict = V_WARNED;
                    end
                    else
                    begin
                        wr_entry.abn_count  = abn_up;
                        result_next.verdict = V_THROTTLED;
                    end
                end
                else
                begin
                    wr_entry.abn_count  = abn_up;
                    result_next.verdict = V_ABNORMAL;
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_per_client_anomaly_monitor.sv
// Self-checking testbench for the per-client anomaly monitor: directed and random packet traffic.
module tb_per_client_anomaly_monitor;
    import pcam_pkg::*;

    localparam int NUM_CLIENTS = 64;
    localparam int PKT_BITS    = 24;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    item_t                item;
    logic                 done;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    logic [31:0] wall_s;
    bit          no_idle;
    int          n_settings;

    // Mirror of the client table plus the queue of verdicts still owed by the block.
    class verdict_board;
        logic [15:0]         rate_limit;
        logic [15:0]         payload_limit;
        logic [7:0]          count_limit;
        bit                  slot_live [NUM_CLIENTS];
        logic [31:0]         win_start [NUM_CLIENTS];
        logic [PKT_BITS-1:0] win_pkts  [NUM_CLIENTS];
        logic [7:0]          abn_cnt   [NUM_CLIENTS];
        bit                  warned    [NUM_CLIENTS];
        result_t             owed_verdicts[$];
        int                  errors;
        int                  items;
        int                  tally [6];

        function new();
            rate_limit    = RST_MAX_PACKET_RATE;
            payload_limit = RST_MAX_PAYLOAD_BYTES;
            count_limit   = RST_ABNORMAL_LIMIT;
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            foreach (tally[i]) tally[i] = 0;
            errors = 0;
            items  = 0;
        endfunction

        function result_t outcome(verdict_t v, logic ok);
            result_t r;
            r.verdict = v;
            r.allowed = ok;
            return r;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_MAX_PACKET_RATE:   rate_limit = data;
                CFG_MAX_PAYLOAD_BYTES: payload_limit = data;
                CFG_ABNORMAL_LIMIT:    count_limit = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_verdicts.size();
        endfunction

        function void note_item(item_t it);
            result_t     r;
            int unsigned s;
            logic [31:0] elapsed;
            logic [63:0] bound;
            bit          bad;
            s = it.client_slot;
            items++;
            if (s >= NUM_CLIENTS)
                r = outcome(V_ABNORMAL, 1'b0);
            else if (it.operation == OP_CLEAR)
            begin
                if (slot_live[s])
                begin
                    abn_cnt[s] = '0;
                    warned[s]  = 1'b0;
                end
                r = outcome(V_CLEARED, 1'b0);
            end
            else if (!slot_live[s])
            begin
                slot_live[s] = 1'b1;
                win_start[s] = it.now_seconds;
                win_pkts[s]  = '0;
                abn_cnt[s]   = '0;
                warned[s]    = 1'b0;
                r = outcome(V_REGISTERED, 1'b1);
            end
            else
            begin
                if (win_pkts[s] != {PKT_BITS{1'b1}})
                    win_pkts[s] += 1'b1;
                bad = 1'b0;
                // elapsed wraps, so a clock that went backwards looks like a long window
                elapsed = it.now_seconds - win_start[s];
                if (elapsed != 0)
                begin
                    bound = (64'(rate_limit) + 64'd1) * 64'(elapsed);
                    if (64'(win_pkts[s]) >= bound)
                        bad = 1'b1;
                    win_pkts[s]  = '0;
                    win_start[s] = it.now_seconds;
                end
                if (it.payload_bytes > payload_limit)
                    bad = 1'b1;
                if (!bad)
                begin
                    if (abn_cnt[s] != 0)
                        abn_cnt[s] -= 1'b1;
                    r = outcome(V_NORMAL, 1'b1);
                end
                else
                begin
                    if (abn_cnt[s] != ABNORMAL_COUNT_MAX)
                        abn_cnt[s] += 1'b1;
                    if (abn_cnt[s] >= count_limit)
                    begin
                        if (!warned[s])
                        begin
                            warned[s]  = 1'b1;
                            abn_cnt[s] = count_limit >> 1;
                            r = outcome(V_WARNED, 1'b0);
                        end
                        else
                            r = outcome(V_THROTTLED, 1'b0);
                    end
                    else
                        r = outcome(V_ABNORMAL, 1'b0);
                end
            end
            owed_verdicts.insert(owed_verdicts.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_verdicts.size() == 0)
            begin
                $error("result with nothing outstanding: verdict %0d allowed %0d",
                       got.verdict, got.allowed);
                errors++;
                return;
            end
            want = owed_verdicts.pop_front();
            tally[int'(want.verdict)]++;
            if (got.verdict !== want.verdict)
            begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                errors++;
            end
            if (got.allowed !== want.allowed)
            begin
                $error("allowed: expected %0d, got %0d", want.allowed, got.allowed);
                errors++;
            end
        endfunction

        function void close_out();
            if (owed_verdicts.size() != 0)
            begin
                $error("%0d results never arrived", owed_verdicts.size());
                errors += owed_verdicts.size();
            end
        endfunction
    endclass

    verdict_board board = new();

    per_client_anomaly_monitor #(
        .NUM_CLIENTS      (NUM_CLIENTS),
        .PACKET_COUNT_BITS(PKT_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_register(cfg_index, cfg_data);
            if (done)
                board.check_result(result);
            if (start && !busy)
                board.note_item(item);
        end
    end

    task automatic send_item(operation_t op, logic [5:0] slot, logic [15:0] pay,
                             logic [31:0] now);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.operation     = op;
        item.client_slot   = slot;
        item.payload_bytes = pay;
        item.now_seconds   = now;
        start = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    // block is idle once nothing is owed; a few spare cycles cover the write-back
    task automatic settle();
        start = 1'b0;
        while (board.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_thresholds(logic [15:0] rate, logic [15:0] plim, logic [7:0] alim);
        settle();
        cfg_write(CFG_MAX_PACKET_RATE, rate);
        cfg_write(CFG_MAX_PAYLOAD_BYTES, plim);
        cfg_write(CFG_ABNORMAL_LIMIT, {8'd0, alim});
        n_settings++;
    endtask

    initial
    begin : stimulus
        logic [15:0] rate;
        logic [15:0] plim;
        logic [7:0]  alim;
        logic [15:0] pay;
        logic [5:0]  slot;
        operation_t  op;
        int          n_items;
        int          hot_base;
        int          hot_n;
        int          over_pct;
        int          clr_pct;
        int unsigned r;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        no_idle    = 1'b0;
        n_settings = 0;
        wall_s     = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: edges of every field, clears, wrap, backwards clock, warn then throttle
        apply_thresholds(16'd100, 16'd1024, 8'd5);
        send_item(OP_PACKET, 6'd0, 16'd0, 32'd0);
        send_item(OP_PACKET, 6'd0, 16'd0, 32'd0);
        send_item(OP_PACKET, 6'd0, 16'hFFFF, 32'd0);
        send_item(OP_CLEAR, 6'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, 6'd63, 16'd0, 32'd0);
        send_item(OP_PACKET, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PACKET, 6'd63, 16'd1024, 32'd0);
        send_item(OP_PACKET, 6'd63, 16'd1025, 32'hFFFF_FFFE);
        send_item(OP_PACKET, 6'd1, 16'd0, 32'd5);
        repeat (8) send_item(OP_PACKET, 6'd1, 16'd2000, 32'd5);
        send_item(OP_CLEAR, 6'd1, 16'd0, 32'd5);
        send_item(OP_PACKET, 6'd1, 16'd2000, 32'd5);
        // limit of zero: first abnormal event warns straight away
        apply_thresholds(16'd0, 16'hFFFF, 8'd0);
        send_item(OP_PACKET, 6'd2, 16'hFFFF, 32'd10);
        send_item(OP_PACKET, 6'd2, 16'hFFFF, 32'd10);
        send_item(OP_PACKET, 6'd2, 16'd0, 32'd11);
        send_item(OP_PACKET, 6'd2, 16'd0, 32'd12);
        send_item(OP_PACKET, 6'd2, 16'd0, 32'd12);
        apply_thresholds(16'hFFFF, 16'd0, 8'd255);
        send_item(OP_PACKET, 6'd2, 16'd1, 32'd100);

        for (int p = 0; p < 8; p++)
        begin
            hot_n    = $urandom_range(2, 8);
            over_pct = 25;
            clr_pct  = 5;
            n_items  = 200;
            case (p)
                0:
                begin
                    rate = 16'd100;
                    plim = 16'd1024;
                    alim = 8'd5;
                end
                1:
                begin
                    rate     = 16'd0;
                    plim     = 16'd0;
                    alim     = 8'd1;
                    over_pct = 50;
                    n_items  = 150;
                end
                2:
                begin
                    rate    = 16'hFFFF;
                    plim    = 16'hFFFF;
                    alim    = 8'd255;
                    n_items = 150;
                    wall_s  = 32'hFFFF_FFF0;
                end
                3:
                begin
                    rate = 16'd3;
                    plim = 16'd512;
                    alim = 8'd4;
                end
                // one slot hammered hard enough to pin its abnormal count at the top
                4:
                begin
                    rate     = 16'd1;
                    plim     = 16'd200;
                    alim     = 8'd130;
                    hot_n    = 1;
                    over_pct = 95;
                    clr_pct  = 0;
                    n_items  = 400;
                end
                5:
                begin
                    rate = 16'($urandom_range(0, 10));
                    plim = 16'($urandom_range(0, 65535));
                    alim = 8'($urandom_range(1, 12));
                end
                6:
                begin
                    rate    = 16'($urandom_range(0, 65535));
                    plim    = 16'($urandom_range(0, 65535));
                    alim    = 8'($urandom_range(0, 255));
                    n_items = 150;
                end
                default:
                begin
                    rate    = 16'd2;
                    plim    = 16'd1024;
                    alim    = 8'd0;
                    n_items = 150;
                end
            endcase
            apply_thresholds(rate, plim, alim);
            hot_base = $urandom_range(0, 63);
            for (int k = 0; k < n_items; k++)
            begin
                if (k % 16 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 85)
                    slot = 6'(hot_base + $urandom_range(0, hot_n - 1));
                else
                    slot = 6'($urandom_range(0, 63));
                op = ($urandom_range(0, 99) < clr_pct) ? OP_CLEAR : OP_PACKET;
                if ($urandom_range(0, 99) < over_pct && plim != 16'hFFFF)
                    pay = 16'($urandom_range(32'(plim) + 1, 65535));
                else if ($urandom_range(0, 9) == 0)
                    pay = 16'($urandom);
                else
                    pay = 16'($urandom_range(0, 32'(plim)));
                // clock mostly holds still so packets pile up within one second
                r = $urandom_range(0, 99);
                if (r >= 80 && r < 92)
                    wall_s += 32'd1;
                else if (r >= 92 && r < 95)
                    wall_s += $urandom_range(2, 4);
                else if (r >= 95 && r < 97)
                    wall_s -= $urandom_range(1, 2);
                else if (r >= 97 && r < 99)
                    wall_s = $urandom;
                else if (r >= 99)
                    wall_s += $urandom_range(100, 100000);
                send_item(op, slot, pay, wall_s);
            end
        end
        no_idle = 1'b0;

        settle();
        board.close_out();
        $display("Covered %0d items over %0d threshold settings, edge values included.",
                 board.items, n_settings);
        $display(
            "Verdicts: reg %0d, normal %0d, abnormal %0d, warned %0d, throttled %0d, cleared %0d",
            board.tally[0], board.tally[1], board.tally[2],
            board.tally[3], board.tally[4], board.tally[5]);
        if (board.errors == 0)
            $display("[per_client_anomaly_monitor] OK");
        else
            $display("[per_client_anomaly_monitor] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(4_000_000);
        $display("[per_client_anomaly_monitor] ERROR");
        $finish;
    end

endmodule
